// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// labeled concurrent assertion on a given clock and active-low reset
`define ETM_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("etm checker: property violated");

// same, on the usual clk_i and rst_ni
`define ETM_ASSERT(lbl, prop) \
  `ETM_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ----- src/etm_pkg.sv -----
// types, constants and helpers for the euler transform matrix block
// no dependencies
`default_nettype none

package etm_pkg;

  // opcodes
  localparam logic [1:0] OP_MODEL  = 2'd0;
  localparam logic [1:0] OP_NORMAL = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;

  // quarter-wave sine polynomial coefficients, Q16
  localparam int unsigned PolyA = 102873;
  localparam int unsigned PolyB = 41906;
  localparam int unsigned PolyC = 4569;

  // datapath widths
  localparam int TrigW   = 18;
  localparam int RotW    = 19;
  localparam int ElW     = 24;
  localparam int DivNW   = 26;
  localparam int DivStep = 2;
  localparam int DivStages = DivNW / DivStep;

  // pipeline depth: sine/cosine, rotation, divider, output
  localparam int SinStages = 5;
  localparam int RotStages = 3;
  localparam int NumStages = SinStages + RotStages + DivStages + 1;

  localparam logic signed [ElW-1:0] ElMax = 24'sh7FFFFF;
  localparam logic signed [ElW-1:0] ElMin = 24'sh800000;

  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [RotW-1:0]  rot_t;
  typedef logic signed [ElW-1:0]   el_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [15:0]         angle_x;
    logic [15:0]         angle_y;
    logic [15:0]         angle_z;
    logic signed [15:0]  scale_x;
    logic signed [15:0]  scale_y;
    logic signed [15:0]  scale_z;
    logic signed [31:0]  move_x;
    logic signed [31:0]  move_y;
    logic signed [31:0]  move_z;
  } etm_in_t;

  typedef struct packed {
    el_t                col0_row0;
    el_t                col0_row1;
    el_t                col0_row2;
    el_t                col1_row0;
    el_t                col1_row1;
    el_t                col1_row2;
    el_t                col2_row0;
    el_t                col2_row1;
    el_t                col2_row2;
    logic signed [31:0] out_move_x;
    logic signed [31:0] out_move_y;
    logic signed [31:0] out_move_z;
  } etm_out_t;

  // fields that ride along the pipeline next to the math
  typedef struct packed {
    logic [1:0]          opcode;
    logic signed [15:0]  scale_x;
    logic signed [15:0]  scale_y;
    logic signed [15:0]  scale_z;
    logic signed [31:0]  move_x;
    logic signed [31:0]  move_y;
    logic signed [31:0]  move_z;
  } etm_side_t;

  // q16 product, floored
  function automatic trig_t qmul(trig_t a, trig_t b);
    logic signed [2*TrigW-1:0] p;
    p = a * b;
    return trig_t'(p >>> 16);
  endfunction

  // clamp a wide signed value to the element range
  function automatic el_t sat_el(logic signed [26:0] v);
    if (v > 27'(ElMax)) begin
      return ElMax;
    end else if (v < 27'(ElMin)) begin
      return ElMin;
    end
    return el_t'(v);
  endfunction

endpackage

`default_nettype wire

// ----- src/etm_if.sv -----
// input and output channel interfaces of the euler transform matrix block
// depends on etm_pkg
`default_nettype none

interface etm_in_if import etm_pkg::*; ();
  logic    valid;
  logic    ready;
  etm_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface etm_out_if import etm_pkg::*; ();
  logic     valid;
  logic     ready;
  etm_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/etm_sincos.sv -----
// five-stage sine and cosine of one binary angle, Q16 result
// depends on etm_pkg
`default_nettype none

module etm_sincos import etm_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic [SinStages-1:0] en_i,
  input  wire logic [15:0]          angle_i,
  output trig_t                     sin_o,
  output trig_t                     cos_o
);

  localparam int QBits = ANGLE_BITS - 2;
  localparam logic [ANGLE_BITS-1:0] Quarter = {2'b01, {QBits{1'b0}}};

  logic [ANGLE_BITS+15:0] wide;
  logic [ANGLE_BITS-1:0]  phase [2];
  trig_t                  res [2];

  // angle to phase of ANGLE_BITS bits, cosine a quarter turn ahead
  assign wide     = {angle_i, {ANGLE_BITS{1'b0}}};
  assign phase[0] = wide[ANGLE_BITS+15:16];
  assign phase[1] = phase[0] + Quarter;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [QBits+15:0] xw;
    logic [16:0]       x_in;
    logic [16:0]       x0_q, x1_q, x2_q, x3_q;
    logic              n0_q, n1_q, n2_q, n3_q;
    logic [16:0]       sq1_q, sq2_q;
    logic [16:0]       t2_q, u3_q;
    logic [33:0]       p1, p2, p3, p4;
    logic [16:0]       sq_d, t_d, u_d, v_d;
    trig_t             s4_q;

    // quadrant fold
    always_comb begin
      xw = {phase[l][QBits-1:0], 16'd0} >> QBits;
      if (phase[l][QBits]) begin
        x_in = 17'd65536 - {1'b0, xw[15:0]};
      end else begin
        x_in = {1'b0, xw[15:0]};
      end
    end

    // polynomial steps, one product each
    always_comb begin
      p1   = 34'(x0_q) * 34'(x0_q);
      sq_d = p1[32:16];
      p2   = 34'(sq1_q) * 34'(PolyC);
      t_d  = 17'(PolyB) - 17'(p2 >> 16);
      p3   = 34'(sq2_q) * 34'(t2_q);
      u_d  = 17'(PolyA) - 17'(p3 >> 16);
      p4   = 34'(x3_q) * 34'(u3_q);
      v_d  = 17'(p4 >> 16);
    end

    always_ff @(posedge clk_i) begin
      if (en_i[0]) begin
        x0_q <= x_in;
        n0_q <= phase[l][ANGLE_BITS-1];
      end
      if (en_i[1]) begin
        x1_q  <= x0_q;
        n1_q  <= n0_q;
        sq1_q <= sq_d;
      end
      if (en_i[2]) begin
        x2_q  <= x1_q;
        n2_q  <= n1_q;
        sq2_q <= sq1_q;
        t2_q  <= t_d;
      end
      if (en_i[3]) begin
        x3_q <= x2_q;
        n3_q <= n2_q;
        u3_q <= u_d;
      end
      if (en_i[4]) begin
        s4_q <= n3_q ? -trig_t'({1'b0, v_d}) : trig_t'({1'b0, v_d});
      end
    end

    assign res[l] = s4_q;
  end

  assign sin_o = res[0];
  assign cos_o = res[1];

endmodule

`default_nettype wire

// ----- src/etm_rot.sv -----
// three-stage build of the Y-X-Z rotation matrix from sine/cosine pairs
// depends on etm_pkg
`default_nettype none

module etm_rot import etm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic [RotStages-1:0] en_i,
  input  trig_t                     s1_i,
  input  trig_t                     c1_i,
  input  trig_t                     s2_i,
  input  trig_t                     c2_i,
  input  trig_t                     s3_i,
  input  trig_t                     c3_i,
  output rot_t                      rot_o [9]
);

  trig_t c1c3_q, s1s2_q, c1s2_q, c3s1_q, c2s3_q, c2c3_q, c2s1_q, c1c2_q, s1s3_q, c1s3_q;
  trig_t s2a_q, s3a_q;
  trig_t t_s1s2s3_q, t_c1s2s3_q, t_c3s1s2_q, t_c1c3s2_q;
  trig_t c1c3b_q, c3s1b_q, c1s3b_q, s1s3b_q, c2s3b_q, c2c3b_q, c2s1b_q, c1c2b_q, s2b_q;
  rot_t  rot_q [9];

  always_ff @(posedge clk_i) begin
    // pair products
    if (en_i[0]) begin
      c1c3_q <= qmul(c1_i, c3_i);
      s1s2_q <= qmul(s1_i, s2_i);
      c1s2_q <= qmul(c1_i, s2_i);
      c3s1_q <= qmul(c3_i, s1_i);
      c2s3_q <= qmul(c2_i, s3_i);
      c2c3_q <= qmul(c2_i, c3_i);
      c2s1_q <= qmul(c2_i, s1_i);
      c1c2_q <= qmul(c1_i, c2_i);
      s1s3_q <= qmul(s1_i, s3_i);
      c1s3_q <= qmul(c1_i, s3_i);
      s2a_q  <= s2_i;
      s3a_q  <= s3_i;
    end
    // triple products, left to right
    if (en_i[1]) begin
      t_s1s2s3_q <= qmul(s1s2_q, s3a_q);
      t_c1s2s3_q <= qmul(c1s2_q, s3a_q);
      t_c3s1s2_q <= qmul(c3s1_q, s2a_q);
      t_c1c3s2_q <= qmul(c1c3_q, s2a_q);
      c1c3b_q <= c1c3_q;
      c3s1b_q <= c3s1_q;
      c1s3b_q <= c1s3_q;
      s1s3b_q <= s1s3_q;
      c2s3b_q <= c2s3_q;
      c2c3b_q <= c2c3_q;
      c2s1b_q <= c2s1_q;
      c1c2b_q <= c1c2_q;
      s2b_q   <= s2a_q;
    end
    // sums
    if (en_i[2]) begin
      rot_q[0] <= rot_t'(c1c3b_q) + rot_t'(t_s1s2s3_q);
      rot_q[1] <= rot_t'(c2s3b_q);
      rot_q[2] <= rot_t'(t_c1s2s3_q) - rot_t'(c3s1b_q);
      rot_q[3] <= rot_t'(t_c3s1s2_q) - rot_t'(c1s3b_q);
      rot_q[4] <= rot_t'(c2c3b_q);
      rot_q[5] <= rot_t'(t_c1c3s2_q) + rot_t'(s1s3b_q);
      rot_q[6] <= rot_t'(c2s1b_q);
      rot_q[7] <= -rot_t'(s2b_q);
      rot_q[8] <= rot_t'(c1c2b_q);
    end
  end

  assign rot_o = rot_q;

endmodule

`default_nettype wire

// ----- src/etm_div.sv -----
// pipelined restoring divider, two quotient bits per stage, for r*256/scale
// depends on etm_pkg
`default_nettype none

module etm_div import etm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic [DivStages-1:0] en_i,
  input  rot_t                      r_i,
  input  wire logic signed [15:0]   sc_i,
  output rot_t                      r_o,
  output logic signed [15:0]        sc_o,
  output logic [DivNW-1:0]          q_o,
  output logic                      neg_o
);

  typedef struct packed {
    logic [16:0]        rem;
    logic [DivNW-1:0]   nq;
    logic [15:0]        d;
    logic               neg;
    rot_t               r;
    logic signed [15:0] sc;
  } div_st_t;

  div_st_t st_q [DivStages];
  div_st_t init;
  rot_t    abs_r;
  logic signed [15:0] neg_sc;

  // magnitudes and quotient sign
  always_comb begin
    abs_r     = r_i[RotW-1] ? -r_i : r_i;
    neg_sc    = -sc_i;
    init.rem  = '0;
    init.nq   = {abs_r[17:0], 8'd0};
    init.d    = sc_i[15] ? neg_sc : sc_i;
    init.neg  = r_i[RotW-1] ^ sc_i[15];
    init.r    = r_i;
    init.sc   = sc_i;
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    div_st_t cur;
    div_st_t nxt;
    logic [16:0] rem_sh;

    if (k == 0) begin : g_first
      assign cur = init;
    end else begin : g_next
      assign cur = st_q[k-1];
    end

    // shift in a dividend bit, subtract when the divisor fits
    always_comb begin
      nxt    = cur;
      rem_sh = '0;
      for (int j = 0; j < DivStep; j++) begin
        rem_sh = {nxt.rem[15:0], nxt.nq[DivNW-1]};
        if (rem_sh >= {1'b0, nxt.d}) begin
          nxt.rem = rem_sh - {1'b0, nxt.d};
          nxt.nq  = {nxt.nq[DivNW-2:0], 1'b1};
        end else begin
          nxt.rem = rem_sh;
          nxt.nq  = {nxt.nq[DivNW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign r_o   = st_q[DivStages-1].r;
  assign sc_o  = st_q[DivStages-1].sc;
  assign q_o   = st_q[DivStages-1].nq;
  assign neg_o = st_q[DivStages-1].neg;

endmodule

`default_nettype wire

// ----- src/euler_transform_matrix.sv -----
// top level: Y-X-Z euler rotation matrix with scale, inverse scale and translation
// depends on etm_pkg, etm_if, etm_sincos, etm_rot, etm_div
//
//   channel | dir | payload   | handshake
//   in_i    | in  | etm_in_t  | valid/ready, beat on both high
//   out_o   | out | etm_out_t | valid/ready, beat on both high
//
// one item per cycle sustained while the output is not blocked
// most of the depth is in the divider: 13 stages of two quotient bits each
// each stage holds while the next one is full and blocked; empty stages fill
// reset clears only the stage valid bits
`default_nettype none

module euler_transform_matrix import etm_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  etm_in_if.sink     in_i,
  etm_out_if.source  out_o
);

  localparam int RotBase = SinStages;
  localparam int DivBase = SinStages + RotStages;
  localparam int OutIdx  = NumStages - 1;

  logic [NumStages-1:0] stage_en;
  logic [NumStages-1:0] valid_d, valid_q;
  etm_side_t            side_in;
  etm_side_t            side_q [OutIdx];
  trig_t                sin_v [3];
  trig_t                cos_v [3];
  rot_t                 rot [9];
  rot_t                 div_r [9];
  logic signed [15:0]   div_sc [9];
  logic [DivNW-1:0]     div_q [9];
  logic                 div_neg [9];
  logic signed [15:0]   scale_sel [9];
  el_t                  el [9];
  etm_out_t             out_d, out_q;

  // stage advance: a stage loads when it is empty or its successor loads
  for (genvar k = 0; k < OutIdx; k++) begin : g_en
    assign stage_en[k] = ~valid_q[k] | stage_en[k+1];
  end
  assign stage_en[OutIdx] = ~valid_q[OutIdx] | out_o.ready;
  assign in_i.ready       = stage_en[0];

  always_comb begin
    valid_d[0] = stage_en[0] ? in_i.valid : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = stage_en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // side fields travel next to the math
  always_comb begin
    side_in.opcode  = in_i.data.opcode;
    side_in.scale_x = in_i.data.scale_x;
    side_in.scale_y = in_i.data.scale_y;
    side_in.scale_z = in_i.data.scale_z;
    side_in.move_x  = in_i.data.move_x;
    side_in.move_y  = in_i.data.move_y;
    side_in.move_z  = in_i.data.move_z;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      side_q[0] <= side_in;
    end
    for (int k = 1; k < OutIdx; k++) begin
      if (stage_en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // sine and cosine: index 0 is angle_y, 1 angle_x, 2 angle_z
  etm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_y (
    .clk_i, .en_i(stage_en[SinStages-1:0]), .angle_i(in_i.data.angle_y),
    .sin_o(sin_v[0]), .cos_o(cos_v[0])
  );
  etm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_x (
    .clk_i, .en_i(stage_en[SinStages-1:0]), .angle_i(in_i.data.angle_x),
    .sin_o(sin_v[1]), .cos_o(cos_v[1])
  );
  etm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_z (
    .clk_i, .en_i(stage_en[SinStages-1:0]), .angle_i(in_i.data.angle_z),
    .sin_o(sin_v[2]), .cos_o(cos_v[2])
  );

  // rotation matrix
  etm_rot u_rot (
    .clk_i,
    .en_i (stage_en[DivBase-1:RotBase]),
    .s1_i (sin_v[0]), .c1_i(cos_v[0]),
    .s2_i (sin_v[1]), .c2_i(cos_v[1]),
    .s3_i (sin_v[2]), .c3_i(cos_v[2]),
    .rot_o(rot)
  );

  // column k uses scale k
  always_comb begin
    for (int e = 0; e < 9; e++) begin
      case (e / 3)
        0:       scale_sel[e] = side_q[DivBase-1].scale_x;
        1:       scale_sel[e] = side_q[DivBase-1].scale_y;
        default: scale_sel[e] = side_q[DivBase-1].scale_z;
      endcase
    end
  end

  // one divider per element
  for (genvar e = 0; e < 9; e++) begin : g_div
    etm_div u_div (
      .clk_i,
      .en_i (stage_en[OutIdx-1:DivBase]),
      .r_i  (rot[e]),
      .sc_i (scale_sel[e]),
      .r_o  (div_r[e]),
      .sc_o (div_sc[e]),
      .q_o  (div_q[e]),
      .neg_o(div_neg[e])
    );
  end

  // final element select and saturation
  for (genvar e = 0; e < 9; e++) begin : g_el
    logic signed [34:0] prod;
    logic signed [26:0] scaled;
    el_t                quot;

    always_comb begin
      prod   = div_r[e] * div_sc[e];
      scaled = 27'(prod >>> 8);
      // normal matrix: clamp the quotient, zero scale goes to the rail of r's sign, or zero when r is zero
      if (div_sc[e] == 16'sd0) begin
        if (div_r[e] > 0) begin
          quot = ElMax;
        end else if (div_r[e] < 0) begin
          quot = ElMin;
        end else begin
          quot = '0;
        end
      end else if (div_neg[e]) begin
        quot = (div_q[e] > DivNW'(24'h800000)) ? ElMin : -el_t'(div_q[e][ElW-1:0]);
      end else begin
        quot = (div_q[e] > DivNW'(24'h7FFFFF)) ? ElMax : el_t'(div_q[e][ElW-1:0]);
      end
      case (side_q[OutIdx-1].opcode)
        OP_MODEL:  el[e] = sat_el(scaled);
        OP_NORMAL: el[e] = quot;
        default:   el[e] = el_t'(div_r[e]);
      endcase
    end
  end

  always_comb begin
    out_d.col0_row0 = el[0];
    out_d.col0_row1 = el[1];
    out_d.col0_row2 = el[2];
    out_d.col1_row0 = el[3];
    out_d.col1_row1 = el[4];
    out_d.col1_row2 = el[5];
    out_d.col2_row0 = el[6];
    out_d.col2_row1 = el[7];
    out_d.col2_row2 = el[8];
    if (side_q[OutIdx-1].opcode == OP_NORMAL) begin
      out_d.out_move_x = '0;
      out_d.out_move_y = '0;
      out_d.out_move_z = '0;
    end else begin
      out_d.out_move_x = side_q[OutIdx-1].move_x;
      out_d.out_move_y = side_q[OutIdx-1].move_y;
      out_d.out_move_z = side_q[OutIdx-1].move_z;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (stage_en[OutIdx]) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = valid_q[OutIdx];
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

// ----- src/etm_checker.sv -----
// port-level checks of the euler transform matrix block, bound to the top level
// depends on etm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module etm_checker import etm_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_ready_i,
  input wire logic     out_valid_i,
  input wire logic     out_ready_i,
  input etm_out_t      out_data_i
);

  // a stalled output beat stays put
  `ETM_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))

  // input is only refused when the output is blocked
  `ETM_ASSERT(a_ready_chain, !in_ready_i |-> out_valid_i && !out_ready_i)

  // pipeline comes out of reset empty
  `ETM_ASSERT(a_reset_empty, $past(!rst_ni) |-> !out_valid_i)

endmodule

bind euler_transform_matrix etm_checker u_etm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

`default_nettype wire
